/* design/utf8d_pkg.sv */
// Package for the UTF-8 stream decoder: types, codes and byte classification
`timescale 1ns / 1ps
`default_nettype none
package utf8d_pkg;

    // counter width default and queue depth
    localparam int OFFSET_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH      = 4;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_TRUNC   = 2'd2;

    // second-byte limit that a lead byte imposes
    localparam logic [2:0] SEC_NONE = 3'd0;
    localparam logic [2:0] SEC_E0   = 3'd1;
    localparam logic [2:0] SEC_ED   = 3'd2;
    localparam logic [2:0] SEC_F0   = 3'd3;
    localparam logic [2:0] SEC_F4   = 3'd4;

    // byte limits
    localparam logic [7:0] LEAD2_LO   = 8'hc2;
    localparam logic [7:0] LEAD2_HI   = 8'hdf;
    localparam logic [7:0] LEAD3_LO   = 8'he0;
    localparam logic [7:0] LEAD4_LO   = 8'hf0;
    localparam logic [7:0] LEAD4_HI   = 8'hf4;
    localparam logic [7:0] LIMIT_A0   = 8'ha0;
    localparam logic [7:0] LIMIT_90   = 8'h90;
    localparam logic [7:0] ASCII_LIM  = 8'h80;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_last;
        logic [2:0] lead_width;
        logic [2:0] sec_kind;
    } byte_info_t;

    // one finished result
    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  char_width;
        logic [1:0]  status;
        logic [31:0] byte_offset;
        logic [31:0] char_index;
        logic        end_of_text;
    } result_t;

    // width of a sequence from its lead byte, 0 for a byte that cannot lead
    function automatic logic [2:0] lead_width_of(input logic [7:0] b);
        logic [2:0] w;
        w = 3'd0;
        if (b < ASCII_LIM)
            w = 3'd1;
        else if (b >= LEAD2_LO && b <= LEAD2_HI)
            w = 3'd2;
        else if (b >= LEAD3_LO && b < LEAD4_LO)
            w = 3'd3;
        else if (b >= LEAD4_LO && b <= LEAD4_HI)
            w = 3'd4;
        return w;
    endfunction

    // second-byte limit class of a lead byte
    function automatic logic [2:0] sec_kind_of(input logic [7:0] b);
        logic [2:0] k;
        unique case (b)
            8'he0:   k = SEC_E0;
            8'hed:   k = SEC_ED;
            8'hf0:   k = SEC_F0;
            8'hf4:   k = SEC_F4;
            default: k = SEC_NONE;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

/* design/utf8d_fifo.sv */
// Small flop-based first-in first-out queue
`timescale 1ns / 1ps
`default_nettype none
module utf8d_fifo #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [DATA_WIDTH-1:0] wr_data,
    output logic                       full,
    input  wire logic                  rd_en,
    output logic [DATA_WIDTH-1:0]      rd_data,
    output logic                       empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

    logic [DATA_WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          do_wr, do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

/* design/utf8d_front.sv */
// Front end: takes raw bytes, classifies them and tags each with its offset
`timescale 1ns / 1ps
`default_nettype none
module utf8d_front #(
    parameter int OFFSET_WIDTH = utf8d_pkg::OFFSET_WIDTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire logic [7:0]               text_byte,
    input  wire logic                     is_last,
    input  wire logic                     q_full,
    output logic                          q_wr,
    output utf8d_pkg::byte_info_t         q_info,
    output logic [OFFSET_WIDTH-1:0]       q_offset
);
    import utf8d_pkg::*;

    localparam logic [OFFSET_WIDTH-1:0] CNT_ONE = OFFSET_WIDTH'(1);

    logic [OFFSET_WIDTH-1:0] byte_cnt_reg, byte_cnt_next;

    // classify the incoming item
    assign q_wr                = push && !q_full;
    assign q_info.text_byte    = text_byte;
    assign q_info.is_last      = is_last;
    assign q_info.lead_width   = lead_width_of(text_byte);
    assign q_info.sec_kind     = sec_kind_of(text_byte);
    assign q_offset            = byte_cnt_reg;

    // byte position, restarted after the last byte of a text
    always_comb
    begin
        byte_cnt_next = byte_cnt_reg;
        if (q_wr)
            byte_cnt_next = is_last ? '0 : byte_cnt_reg + CNT_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_cnt_reg <= '0;
        else
            byte_cnt_reg <= byte_cnt_next;
    end

endmodule
`default_nettype wire

/* design/utf8d_back.sv */
// Back end: runs the sequence decoder over classified bytes and forms results
`timescale 1ns / 1ps
`default_nettype none
module utf8d_back #(
    parameter int OFFSET_WIDTH = utf8d_pkg::OFFSET_WIDTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     q_empty,
    input  wire utf8d_pkg::byte_info_t    q_info,
    input  wire logic [OFFSET_WIDTH-1:0]  q_offset,
    output logic                          q_rd,
    input  wire logic                     r_full,
    output logic                          r_wr,
    output utf8d_pkg::result_t            r_data
);
    import utf8d_pkg::*;

    localparam logic [OFFSET_WIDTH-1:0] CNT_ONE = OFFSET_WIDTH'(1);

    logic [20:0]             partial_reg, partial_next;
    logic [1:0]              needed_reg, needed_next;
    logic [2:0]              seq_width_reg, seq_width_next;
    logic [2:0]              sec_kind_reg, sec_kind_next;
    logic [OFFSET_WIDTH-1:0] seq_start_reg, seq_start_next;
    logic [OFFSET_WIDTH-1:0] char_cnt_reg, char_cnt_next;

    logic                    proc;
    logic                    emit;
    logic [20:0]             cp;
    logic [2:0]              width;
    logic [1:0]              status;
    logic [OFFSET_WIDTH-1:0] off;
    logic                    cont_ok;
    logic                    sec_ok;
    logic [20:0]             shifted;
    logic [7:0]              b;

    assign proc = !q_empty && !r_full;
    assign q_rd = proc;
    assign b    = q_info.text_byte;

    // continuation check, with the tighter second-byte limits
    always_comb
    begin
        unique case (sec_kind_reg)
            SEC_E0:  sec_ok = (b >= LIMIT_A0);
            SEC_ED:  sec_ok = (b < LIMIT_A0);
            SEC_F0:  sec_ok = (b >= LIMIT_90);
            SEC_F4:  sec_ok = (b < LIMIT_90);
            default: sec_ok = 1'b1;
        endcase
        cont_ok = (b[7:6] == 2'b10) &&
                  (sec_ok || ({1'b0, needed_reg} + 3'd1 != seq_width_reg));
        shifted = {partial_reg[14:0], b[5:0]};
    end

    // decode step
    always_comb
    begin
        partial_next   = partial_reg;
        needed_next    = needed_reg;
        seq_width_next = seq_width_reg;
        sec_kind_next  = sec_kind_reg;
        seq_start_next = seq_start_reg;
        char_cnt_next  = char_cnt_reg;
        emit           = 1'b0;
        cp             = '0;
        width          = '0;
        status         = STATUS_OK;
        off            = '0;

        if (needed_reg == 2'd0)
        begin
            unique case (q_info.lead_width)
                3'd1:
                begin
                    emit  = 1'b1;
                    cp    = {13'd0, b};
                    width = 3'd1;
                    off   = q_offset;
                end
                3'd2, 3'd3, 3'd4:
                begin
                    unique case (q_info.lead_width)
                        3'd2:    partial_next = {16'd0, b[4:0]};
                        3'd3:    partial_next = {17'd0, b[3:0]};
                        default: partial_next = {18'd0, b[2:0]};
                    endcase
                    seq_width_next = q_info.lead_width;
                    needed_next    = 2'(q_info.lead_width - 3'd1);
                    sec_kind_next  = q_info.sec_kind;
                    seq_start_next = q_offset;
                    if (q_info.is_last)
                    begin
                        emit   = 1'b1;
                        status = STATUS_TRUNC;
                        off    = q_offset;
                    end
                end
                default:
                begin
                    emit   = 1'b1;
                    status = STATUS_INVALID;
                    off    = q_offset;
                end
            endcase
        end
        else if (cont_ok)
        begin
            needed_next = needed_reg - 2'd1;
            if (needed_reg == 2'd1)
            begin
                emit           = 1'b1;
                cp             = shifted;
                width          = seq_width_reg;
                off            = seq_start_reg;
                partial_next   = '0;
                seq_width_next = '0;
                sec_kind_next  = SEC_NONE;
                seq_start_next = '0;
            end
            else
            begin
                partial_next = shifted;
                if (q_info.is_last)
                begin
                    emit   = 1'b1;
                    status = STATUS_TRUNC;
                    off    = seq_start_reg;
                end
            end
        end
        else
        begin
            emit           = 1'b1;
            status         = STATUS_INVALID;
            off            = seq_start_reg;
            partial_next   = '0;
            needed_next    = '0;
            seq_width_next = '0;
            sec_kind_next  = SEC_NONE;
            seq_start_next = '0;
        end

        if (emit && status == STATUS_OK)
            char_cnt_next = char_cnt_reg + CNT_ONE;

        // end of text clears everything
        if (q_info.is_last)
        begin
            partial_next   = '0;
            needed_next    = '0;
            seq_width_next = '0;
            sec_kind_next  = SEC_NONE;
            seq_start_next = '0;
            char_cnt_next  = '0;
        end
    end

    // result item
    assign r_wr               = proc && emit;
    assign r_data.code_point  = cp;
    assign r_data.char_width  = width;
    assign r_data.status      = status;
    assign r_data.byte_offset = 32'(off);
    assign r_data.char_index  = 32'(char_cnt_reg);
    assign r_data.end_of_text = q_info.is_last;

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            needed_reg    <= '0;
            seq_width_reg <= '0;
            sec_kind_reg  <= SEC_NONE;
            seq_start_reg <= '0;
            char_cnt_reg  <= '0;
        end
        else if (proc)
        begin
            partial_reg   <= partial_next;
            needed_reg    <= needed_next;
            seq_width_reg <= seq_width_next;
            sec_kind_reg  <= sec_kind_next;
            seq_start_reg <= seq_start_next;
            char_cnt_reg  <= char_cnt_next;
        end
    end

endmodule
`default_nettype wire

/* design/utf8_stream_decoder_unit.sv */
// Top level of the strict UTF-8 stream decoder
//
// Input channel: one text byte per item with an is_last marker; an item is
// taken at a clock edge with push high and full low. Result channel: the
// oldest result is on the output ports while empty is low and leaves at an
// edge with pop high. Each byte yields zero or one result: a code point with
// its width, status, start offset, character index and end-of-text flag.
// A byte passes through the byte queue to the back end, which decodes it and
// writes any result into the result queue, whose oldest item is on the ports.
// Throughput: one byte per cycle while no queue is full; the byte queue and
// the result queue (four items each) let both sides stall independently, so
// the input keeps flowing until both queues fill up behind a stalled reader.
// Invalid bytes and truncated sequences give error results and decoding
// continues. After a byte marked last, offsets and character counts restart
// at zero. Reset clears both queues, the counters and any pending sequence.
`timescale 1ns / 1ps
`default_nettype none
module utf8_stream_decoder_unit #(
    parameter int OFFSET_WIDTH = utf8d_pkg::OFFSET_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  text_byte,
    input  wire logic        is_last,
    output logic             empty,
    input  wire logic        pop,
    output logic [20:0]      code_point,
    output logic [2:0]       char_width,
    output logic [1:0]       status,
    output logic [31:0]      byte_offset,
    output logic [31:0]      char_index,
    output logic             end_of_text
);
    import utf8d_pkg::*;

    localparam int INFO_W = $bits(byte_info_t);
    localparam int MID_W  = INFO_W + OFFSET_WIDTH;
    localparam int RES_W  = $bits(result_t);

    logic                    mid_wr, mid_full, mid_rd, mid_empty;
    byte_info_t              front_info, back_info;
    logic [OFFSET_WIDTH-1:0] front_offset, back_offset;
    logic [MID_W-1:0]        mid_out;
    logic                    res_wr, res_full;
    result_t                 res_in, res_out;

    assign full = mid_full;

    // classify and tag bytes
    utf8d_front #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .text_byte (text_byte),
        .is_last   (is_last),
        .q_full    (mid_full),
        .q_wr      (mid_wr),
        .q_info    (front_info),
        .q_offset  (front_offset)
    );

    // byte queue between front and back
    utf8d_fifo #(.DATA_WIDTH(MID_W), .DEPTH(QUEUE_DEPTH)) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_wr),
        .wr_data ({front_info, front_offset}),
        .full    (mid_full),
        .rd_en   (mid_rd),
        .rd_data (mid_out),
        .empty   (mid_empty)
    );

    assign back_info   = mid_out[MID_W-1:OFFSET_WIDTH];
    assign back_offset = mid_out[OFFSET_WIDTH-1:0];

    // sequence decoder
    utf8d_back #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (mid_empty),
        .q_info   (back_info),
        .q_offset (back_offset),
        .q_rd     (mid_rd),
        .r_full   (res_full),
        .r_wr     (res_wr),
        .r_data   (res_in)
    );

    // result queue toward the reader
    utf8d_fifo #(.DATA_WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign code_point  = res_out.code_point;
    assign char_width  = res_out.char_width;
    assign status      = res_out.status;
    assign byte_offset = res_out.byte_offset;
    assign char_index  = res_out.char_index;
    assign end_of_text = res_out.end_of_text;

endmodule
`default_nettype wire

/* tb/sv/utf8_stream_decoder_unit_tb.sv */
// Self-checking bench for the strict UTF-8 stream decoder: byte driver, result checker, decoder predictor
`timescale 1ns / 1ps
module utf8_stream_decoder_unit_tb;
    import utf8d_pkg::*;

    localparam int RANDOM_BYTES = 2000;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int CALM_FROM    = 1000;
    localparam int CALM_TO      = 1600;

    // one byte waiting to be sent; drain makes the sender wait for all results first
    typedef struct {
        logic [7:0] b;
        logic       last;
        bit         drain;
    } text_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  text_byte = 8'h00;
    logic        is_last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [20:0] code_point;
    logic [2:0]  char_width;
    logic [1:0]  status;
    logic [31:0] byte_offset;
    logic [31:0] char_index;
    logic        end_of_text;

    text_item_t  text_items[$];
    result_t     expected_chars[$];
    int          fault_count = 0;
    int          stall_cycles = 0;
    int          cycle_count = 0;

    // predictor state
    logic [20:0] partial;
    logic [1:0]  need;
    logic [2:0]  seq_w;
    logic [7:0]  lead;
    logic [31:0] byte_pos;
    logic [31:0] seq_start;
    logic [31:0] char_count;

    utf8_stream_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .text_byte   (text_byte),
        .is_last     (is_last),
        .empty       (empty),
        .pop         (pop),
        .code_point  (code_point),
        .char_width  (char_width),
        .status      (status),
        .byte_offset (byte_offset),
        .char_index  (char_index),
        .end_of_text (end_of_text)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // drop any open sequence
    task automatic clear_sequence();
        partial   = '0;
        need      = '0;
        seq_w     = '0;
        lead      = '0;
        seq_start = '0;
    endtask

    // decode one accepted byte and queue the result it causes, if any
    task automatic decode_byte(input logic [7:0] b, input logic last);
        result_t    r;
        logic [2:0] w;
        logic       emit;
        logic       cont_ok;
        r = '0;
        r.char_index  = char_count;
        r.end_of_text = last;
        r.status      = STATUS_OK;
        emit = 1'b0;
        if (need == 2'd0)
        begin
            // lead byte classification
            if (b < 8'h80)
                w = 3'd1;
            else if (b >= 8'hc2 && b <= 8'hdf)
                w = 3'd2;
            else if (b >= 8'he0 && b <= 8'hef)
                w = 3'd3;
            else if (b >= 8'hf0 && b <= 8'hf4)
                w = 3'd4;
            else
                w = 3'd0;
            if (w == 3'd1)
            begin
                emit = 1'b1;
                r.code_point  = {13'd0, b};
                r.char_width  = 3'd1;
                r.byte_offset = byte_pos;
            end
            else if (w == 3'd0)
            begin
                emit = 1'b1;
                r.status      = STATUS_INVALID;
                r.byte_offset = byte_pos;
            end
            else
            begin
                case (w)
                    3'd2:    partial = {16'd0, b[4:0]};
                    3'd3:    partial = {17'd0, b[3:0]};
                    default: partial = {18'd0, b[2:0]};
                endcase
                seq_w     = w;
                need      = 2'(w - 3'd1);
                lead      = b;
                seq_start = byte_pos;
                if (last)
                begin
                    emit = 1'b1;
                    r.status      = STATUS_TRUNC;
                    r.byte_offset = byte_pos;
                end
            end
        end
        else
        begin
            // continuation byte, with the tighter second-byte range after some leads
            cont_ok = (b[7:6] == 2'b10);
            if (cont_ok && ({1'b0, need} + 3'd1 == seq_w))
            begin
                case (lead)
                    8'he0:   cont_ok = (b >= LIMIT_A0);
                    8'hed:   cont_ok = (b < LIMIT_A0);
                    8'hf0:   cont_ok = (b >= LIMIT_90);
                    8'hf4:   cont_ok = (b < LIMIT_90);
                    default: cont_ok = 1'b1;
                endcase
            end
            if (cont_ok)
            begin
                partial = {partial[14:0], b[5:0]};
                need    = need - 2'd1;
                if (need == 2'd0)
                begin
                    emit = 1'b1;
                    r.code_point  = partial;
                    r.char_width  = seq_w;
                    r.byte_offset = seq_start;
                    clear_sequence();
                end
                else if (last)
                begin
                    emit = 1'b1;
                    r.status      = STATUS_TRUNC;
                    r.byte_offset = seq_start;
                end
            end
            else
            begin
                emit = 1'b1;
                r.status      = STATUS_INVALID;
                r.byte_offset = seq_start;
                clear_sequence();
            end
        end
        // counters, restarted after the last byte of a text
        if (emit && r.status == STATUS_OK)
            char_count = char_count + 32'd1;
        byte_pos = byte_pos + 32'd1;
        if (last)
        begin
            clear_sequence();
            byte_pos   = '0;
            char_count = '0;
        end
        if (emit)
            expected_chars.push_back(r);
    endtask

    task automatic add_byte(input logic [7:0] b, input logic last);
        text_item_t t;
        t.b     = b;
        t.last  = last;
        t.drain = 1'b0;
        text_items.push_back(t);
    endtask

    // encode a code point; keep cuts the sequence short, spoil_at replaces one byte
    task automatic add_char(input logic [20:0] cp, input int keep, input int spoil_at,
                            input logic last_on_end);
        logic [7:0] seq [4];
        int n;
        if (cp < 21'h80)
        begin
            n = 1;
            seq[0] = {1'b0, cp[6:0]};
        end
        else if (cp < 21'h800)
        begin
            n = 2;
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000)
        begin
            n = 3;
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            n = 4;
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
        end
        if (keep < n)
            n = keep;
        for (int i = 0; i < n; i++)
            add_byte((i == spoil_at) ? 8'($urandom_range(255)) : seq[i],
                     last_on_end && (i == n - 1));
    endtask

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // byte driver: takes items from the pending queue, idles at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push      <= 1'b0;
            text_byte <= 8'h00;
            is_last   <= 1'b0;
        end
        else
        begin
            if (push && !full)
                decode_byte(text_byte, is_last);
            if (!push || !full)
            begin
                if (text_items.size() != 0
                    && !(text_items[0].drain && expected_chars.size() != 0)
                    && ((cycle_count >= CALM_FROM && cycle_count < CALM_TO)
                        || $urandom_range(99) >= 36))
                begin
                    push      <= 1'b1;
                    text_byte <= text_items[0].b;
                    is_last   <= text_items[0].last;
                    void'(text_items.pop_front());
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // result checker: compares each popped result with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin : check_char
                result_t want;
                if (expected_chars.size() == 0)
                begin
                    fault_count <= fault_count + 1;
                    if (fault_count < 10)
                        $display("unexpected result: cp=%h w=%0d st=%0d off=%0d idx=%0d eot=%0b",
                                 code_point, char_width, status, byte_offset, char_index,
                                 end_of_text);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (code_point !== want.code_point || char_width !== want.char_width
                        || status !== want.status || byte_offset !== want.byte_offset
                        || char_index !== want.char_index
                        || end_of_text !== want.end_of_text)
                    begin
                        fault_count <= fault_count + 1;
                        if (fault_count < 10)
                        begin
                            $display("expected cp=%h w=%0d st=%0d off=%0d idx=%0d eot=%0b",
                                     want.code_point, want.char_width, want.status,
                                     want.byte_offset, want.char_index, want.end_of_text);
                            $display("actual   cp=%h w=%0d st=%0d off=%0d idx=%0d eot=%0b",
                                     code_point, char_width, status, byte_offset, char_index,
                                     end_of_text);
                        end
                    end
                end
            end
            pop <= (cycle_count >= CALM_FROM && cycle_count < CALM_TO)
                   || ($urandom_range(99) >= 36);
        end
    end

    // watchdog on cycles in which neither side moves an item
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        int         first_random;
        int         kind;
        logic [20:0] cp;

        clear_sequence();
        byte_pos   = '0;
        char_count = '0;

        // directed: ascii extremes, smallest two-byte and largest scalar
        add_byte(8'h00, 1'b0);
        add_byte(8'h7f, 1'b0);
        add_char(21'h80, 4, -1, 1'b0);
        add_char(21'h10ffff, 4, -1, 1'b1);
        // second-byte limits: overlong, surrogate, overlong, above range
        add_byte(8'he0, 1'b0);
        add_byte(8'h9f, 1'b0);
        add_byte(8'hed, 1'b0);
        add_byte(8'ha0, 1'b0);
        add_byte(8'hf0, 1'b0);
        add_byte(8'h8f, 1'b0);
        add_byte(8'hf4, 1'b0);
        add_byte(8'h90, 1'b0);
        // bytes that cannot lead
        add_byte(8'hc1, 1'b0);
        add_byte(8'hff, 1'b0);
        add_byte(8'h80, 1'b0);
        // non-continuation inside a sequence, on the last byte
        add_byte(8'hc3, 1'b0);
        add_byte(8'h41, 1'b1);
        // truncated mid-sequence and truncated at the lead
        add_byte(8'he2, 1'b0);
        add_byte(8'h82, 1'b1);
        add_byte(8'hf0, 1'b1);

        // random: mostly well-formed characters, some spoiled, cut or noise
        first_random = text_items.size();
        while (text_items.size() < first_random + RANDOM_BYTES)
        begin
            case ($urandom_range(3))
                0: cp = 21'($urandom_range(21'h7f));
                1: cp = 21'($urandom_range(21'h7ff, 21'h80));
                2:
                    case ($urandom_range(3))
                        0:       cp = 21'($urandom_range(21'hfff, 21'h800));
                        1:       cp = 21'($urandom_range(21'hd7ff, 21'hd000));
                        2:       cp = 21'($urandom_range(21'hcfff, 21'h1000));
                        default: cp = 21'($urandom_range(21'hffff, 21'he000));
                    endcase
                default:
                    case ($urandom_range(2))
                        0:       cp = 21'($urandom_range(21'h3ffff, 21'h10000));
                        1:       cp = 21'($urandom_range(21'h10ffff, 21'h100000));
                        default: cp = 21'($urandom_range(21'hfffff, 21'h40000));
                    endcase
            endcase
            kind = $urandom_range(99);
            if (kind < 70)
                add_char(cp, 4, -1, $urandom_range(24) == 0);
            else if (kind < 80)
                add_char(cp, 4, $urandom_range(3), $urandom_range(7) == 0);
            else if (kind < 88)
                add_char(cp, $urandom_range(3, 1), -1, $urandom_range(1) == 1);
            else
                add_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
        end
        // sender waits for all results here
        text_items[first_random].drain = 1'b1;
        text_items[first_random + RANDOM_BYTES / 2].drain = 1'b1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // wait for all bytes to go in and all results to come out
        while (text_items.size() != 0 || push)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
